// ----- sv/lloyd_palette_refiner_unit_macros.svh -----
// Assertion macros for the palette refiner.
`ifndef LLOYD_PALETTE_REFINER_UNIT_MACROS_SVH
`define LLOYD_PALETTE_REFINER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define LPR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lpr assertion failed");
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lpr assertion failed");
`else
`define LPR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define LPR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/lpr_pkg.sv -----
`default_nettype none
package lpr_pkg;
  localparam int MaxEntries = 256;
  localparam int IdxW = 8;
  localparam int CntW = 24;
  localparam int SumW = CntW + 5;
  localparam int DistW = 14;
  localparam int SizeW = 9;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_BIN = 2'd1;
  localparam logic [1:0] OP_FINISH = 2'd2;
  localparam logic [1:0] OP_READ = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_SCAN, ST_SCAN_LAST, ST_ACC_RD, ST_ACC_WR,
    ST_FIN_RD, ST_FIN_CHK, ST_FIN_DIV, ST_FIN_WR, ST_REPORT_RD, ST_REPORT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             capture;
    logic             clr_wr;
    logic             scan_rd;
    logic             scan_cmp;
    logic             scan_first;
    logic             acc_rd;
    logic             acc_wr;
    logic             fin_rd;
    logic             div_start;
    logic             fin_wr;
    logic             rep_rd;
    logic             emit;
    logic [IdxW-1:0]  addr;
  } cmd_t;

  typedef struct packed {
    logic            div_done;
    logic            weight_zero;
    logic [IdxW-1:0] best;
  } status_t;
endpackage
`default_nettype wire

// ----- sv/lpr_divider.sv -----
`default_nettype none
// Restoring divider: one quotient bit per cycle, sum and weight of one channel.
module lpr_divider (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [lpr_pkg::SumW-1:0]  dividend,
  input  wire logic [lpr_pkg::CntW-1:0]  divisor,
  output logic                           done,
  output logic [4:0]                     mean
);
  localparam int NumW = lpr_pkg::SumW + 1;
  localparam int StepW = $clog2(NumW + 1);
  logic [NumW-1:0] num;
  logic [NumW-1:0] quo;
  logic [lpr_pkg::CntW:0] rem;
  logic [lpr_pkg::CntW-1:0] dvs;
  logic [StepW-1:0] step;
  logic busy;
  logic [lpr_pkg::CntW+1:0] trial;

  assign trial = {rem, num[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        // Rounded mean: (sum + w/2) / w.
        num <= {1'b0, dividend} + NumW'(divisor >> 1);
        dvs <= divisor;
        rem <= '0;
        quo <= '0;
        step <= StepW'(NumW);
      end else if (busy) begin
        if (trial >= {2'b00, dvs}) begin
          rem <= (lpr_pkg::CntW+1)'(trial - {2'b00, dvs});
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= trial[lpr_pkg::CntW:0];
          quo <= {quo[NumW-2:0], 1'b0};
        end
        num <= {num[NumW-2:0], 1'b0};
        step <= step - 1'b1;
        if (step == StepW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (quo > NumW'(31)) mean = 5'd31;
    else mean = quo[4:0];
  end
endmodule
`default_nettype wire

// ----- sv/lpr_datapath.sv -----
`default_nettype none
`include "lloyd_palette_refiner_unit_macros.svh"
module lpr_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire lpr_pkg::cmd_t               cmd,
  output lpr_pkg::status_t                 status,
  input  wire logic [1:0]                  operation,
  input  wire logic [lpr_pkg::IdxW-1:0]    entry_index,
  input  wire logic [4:0]                  red,
  input  wire logic [4:0]                  green,
  input  wire logic [4:0]                  blue,
  input  wire logic [lpr_pkg::CntW-1:0]    pixel_count,
  output logic                             done,
  output logic [lpr_pkg::IdxW-1:0]         result_index,
  output logic [lpr_pkg::DistW-1:0]        result_distance,
  output logic [4:0]                       result_red,
  output logic [4:0]                       result_green,
  output logic [4:0]                       result_blue
);
  localparam int AccW = lpr_pkg::CntW + 3 * lpr_pkg::SumW;
  localparam logic [lpr_pkg::CntW-1:0] WMax = '1;
  localparam logic [lpr_pkg::SumW-1:0] SMax = '1;

  logic [14:0] pal_mem [lpr_pkg::MaxEntries];
  logic [AccW-1:0] acc_mem [lpr_pkg::MaxEntries];
  logic [14:0] pal_q;
  logic [AccW-1:0] acc_q;

  logic [1:0] op;
  logic [lpr_pkg::IdxW-1:0] idx;
  logic [4:0] r, g, b;
  logic [lpr_pkg::CntW-1:0] cnt;

  logic [lpr_pkg::IdxW-1:0] rd_idx, best;
  logic [lpr_pkg::DistW-1:0] best_d;
  logic [14:0] best_e;

  logic [lpr_pkg::CntW-1:0] acc_w;
  logic [lpr_pkg::SumW-1:0] acc_r, acc_g, acc_b;
  logic [lpr_pkg::SumW-1:0] prod_r, prod_g, prod_b;
  logic [4:0] mean_r, mean_g, mean_b;
  logic dr_done, dg_done, db_done;
  logic [lpr_pkg::CntW:0] w_sum;
  logic [lpr_pkg::SumW:0] r_sum, g_sum, b_sum;
  logic [lpr_pkg::CntW-1:0] w_new;
  logic [lpr_pkg::SumW-1:0] r_new, g_new, b_new;

  logic signed [5:0] dr, dg, db;
  logic [lpr_pkg::DistW-1:0] cand_dist;

  assign {acc_w, acc_r, acc_g, acc_b} = acc_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= operation;
      idx <= entry_index;
      r <= red;
      g <= green;
      b <= blue;
      cnt <= pixel_count;
    end
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.capture && operation == lpr_pkg::OP_LOAD) begin
      pal_mem[entry_index] <= {red, green, blue};
    end else if (cmd.fin_wr) begin
      pal_mem[cmd.addr] <= {mean_r, mean_g, mean_b};
    end
    pal_q <= pal_mem[cmd.addr];
    rd_idx <= cmd.addr;
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) begin
      acc_mem[cmd.addr] <= '0;
    end else if (cmd.acc_wr) begin
      acc_mem[cmd.addr] <= {w_new, r_new, g_new, b_new};
    end
    acc_q <= acc_mem[cmd.addr];
  end

  always_comb begin
    dr = $signed({1'b0, pal_q[14:10]}) - $signed({1'b0, r});
    dg = $signed({1'b0, pal_q[9:5]}) - $signed({1'b0, g});
    db = $signed({1'b0, pal_q[4:0]}) - $signed({1'b0, b});
    cand_dist = lpr_pkg::DistW'(3 * dr * dr + 6 * dg * dg + db * db);
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_cmp) begin
      if (cmd.scan_first || cand_dist < best_d) begin
        best_d <= cand_dist;
        best <= rd_idx;
        best_e <= pal_q;
      end
    end
  end

  // Channel products registered ahead of the saturating add.
  always_ff @(posedge clk) begin
    prod_r <= lpr_pkg::SumW'(r) * lpr_pkg::SumW'(cnt);
    prod_g <= lpr_pkg::SumW'(g) * lpr_pkg::SumW'(cnt);
    prod_b <= lpr_pkg::SumW'(b) * lpr_pkg::SumW'(cnt);
  end

  always_comb begin
    w_sum = {1'b0, acc_w} + {1'b0, cnt};
    r_sum = {1'b0, acc_r} + {1'b0, prod_r};
    g_sum = {1'b0, acc_g} + {1'b0, prod_g};
    b_sum = {1'b0, acc_b} + {1'b0, prod_b};
    w_new = w_sum[lpr_pkg::CntW] ? WMax : w_sum[lpr_pkg::CntW-1:0];
    r_new = r_sum[lpr_pkg::SumW] ? SMax : r_sum[lpr_pkg::SumW-1:0];
    g_new = g_sum[lpr_pkg::SumW] ? SMax : g_sum[lpr_pkg::SumW-1:0];
    b_new = b_sum[lpr_pkg::SumW] ? SMax : b_sum[lpr_pkg::SumW-1:0];
  end

  lpr_divider u_div_r (.clk(clk), .rst(rst), .start(cmd.div_start), .dividend(acc_r),
    .divisor(acc_w), .done(dr_done), .mean(mean_r));
  lpr_divider u_div_g (.clk(clk), .rst(rst), .start(cmd.div_start), .dividend(acc_g),
    .divisor(acc_w), .done(dg_done), .mean(mean_g));
  lpr_divider u_div_b (.clk(clk), .rst(rst), .start(cmd.div_start), .dividend(acc_b),
    .divisor(acc_w), .done(db_done), .mean(mean_b));

  assign status.div_done = dr_done;
  assign status.weight_zero = (acc_w == '0);
  assign status.best = best;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.emit;
    end
    if (cmd.emit) begin
      if (op == lpr_pkg::OP_BIN) begin
        result_index <= best;
        result_distance <= best_d;
        {result_red, result_green, result_blue} <= best_e;
      end else begin
        result_index <= idx;
        result_distance <= '0;
        {result_red, result_green, result_blue} <= pal_q;
      end
    end
  end

  `LPR_ASSERT_IMPL(a_div_lockstep, clk, rst, dr_done, dg_done && db_done)
  `LPR_ASSERT_NEXT(a_emit_done, clk, rst, cmd.emit, done)
  `LPR_ASSERT_IMPL(a_no_dual_wr, clk, rst, cmd.acc_wr, !cmd.clr_wr)
endmodule
`default_nettype wire

// ----- sv/lpr_controller.sv -----
`default_nettype none
`include "lloyd_palette_refiner_unit_macros.svh"
module lpr_controller (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [1:0]                  operation,
  input  wire logic [lpr_pkg::IdxW-1:0]    entry_index,
  input  wire logic [lpr_pkg::SizeW-1:0]   palette_size,
  input  wire lpr_pkg::status_t            status,
  output lpr_pkg::cmd_t                    cmd,
  output logic                             busy
);
  lpr_pkg::state_t state, state_next;
  logic [lpr_pkg::IdxW-1:0] ptr, ptr_next;
  logic [lpr_pkg::IdxW-1:0] last;
  logic [lpr_pkg::IdxW-1:0] idx, idx_next;
  logic first, first_next;

  // Index of the last entry in use, with the size clamped to one through 256.
  always_comb begin
    if (palette_size == '0) last = '0;
    else if (palette_size > lpr_pkg::SizeW'(lpr_pkg::MaxEntries)) last = '1;
    else last = lpr_pkg::IdxW'(palette_size - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpr_pkg::ST_CLEAR;
      ptr <= '0;
      idx <= '0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      idx <= idx_next;
      first <= first_next;
    end
  end

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    idx_next = idx;
    first_next = 1'b0;
    cmd = '0;
    cmd.addr = ptr;
    busy = 1'b1;
    unique case (state)
      lpr_pkg::ST_IDLE: begin
        busy = 1'b0;
        cmd.addr = entry_index;
        if (start) begin
          cmd.capture = 1'b1;
          idx_next = entry_index;
          ptr_next = '0;
          unique case (operation)
            lpr_pkg::OP_BIN: begin
              cmd.addr = '0;
              first_next = 1'b1;
              ptr_next = 8'd1;
              state_next = (last == '0) ? lpr_pkg::ST_SCAN_LAST : lpr_pkg::ST_SCAN;
            end
            lpr_pkg::OP_FINISH: begin
              cmd.addr = '0;
              state_next = lpr_pkg::ST_FIN_RD;
            end
            default: state_next = lpr_pkg::ST_REPORT_RD;
          endcase
        end
      end
      lpr_pkg::ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        ptr_next = ptr + 1'b1;
        if (ptr == '1) state_next = lpr_pkg::ST_IDLE;
      end
      lpr_pkg::ST_SCAN: begin
        // Compare the entry read last cycle while reading the next one.
        cmd.scan_cmp = 1'b1;
        cmd.scan_first = first;
        ptr_next = ptr + 1'b1;
        if (ptr == last) state_next = lpr_pkg::ST_SCAN_LAST;
      end
      lpr_pkg::ST_SCAN_LAST: begin
        cmd.scan_cmp = 1'b1;
        cmd.scan_first = first;
        state_next = lpr_pkg::ST_ACC_RD;
      end
      lpr_pkg::ST_ACC_RD: begin
        // Best index is known only after the last compare; the datapath holds it.
        cmd.acc_rd = 1'b1;
        cmd.addr = status.best;
        state_next = lpr_pkg::ST_ACC_WR;
      end
      lpr_pkg::ST_ACC_WR: begin
        cmd.acc_wr = 1'b1;
        cmd.addr = status.best;
        cmd.emit = 1'b1;
        state_next = lpr_pkg::ST_IDLE;
      end
      lpr_pkg::ST_FIN_RD: begin
        // Read the accumulators of the current entry; they are valid next cycle.
        cmd.fin_rd = 1'b1;
        state_next = lpr_pkg::ST_FIN_CHK;
      end
      lpr_pkg::ST_FIN_CHK: begin
        state_next = status.weight_zero ? lpr_pkg::ST_FIN_WR : lpr_pkg::ST_FIN_DIV;
        cmd.div_start = !status.weight_zero;
      end
      lpr_pkg::ST_FIN_DIV: begin
        if (status.div_done) begin
          cmd.fin_wr = 1'b1;
          state_next = lpr_pkg::ST_FIN_WR;
        end
      end
      lpr_pkg::ST_FIN_WR: begin
        cmd.clr_wr = 1'b1;
        ptr_next = ptr + 1'b1;
        if (ptr == '1) state_next = lpr_pkg::ST_REPORT_RD;
        else state_next = lpr_pkg::ST_FIN_RD;
      end
      lpr_pkg::ST_REPORT_RD: begin
        cmd.addr = idx;
        cmd.rep_rd = 1'b1;
        state_next = lpr_pkg::ST_REPORT;
      end
      lpr_pkg::ST_REPORT: begin
        cmd.addr = idx;
        cmd.emit = 1'b1;
        state_next = lpr_pkg::ST_IDLE;
      end
      default: state_next = lpr_pkg::ST_IDLE;
    endcase
  end

  `LPR_ASSERT_IMPL(a_idle_free, clk, rst, state == lpr_pkg::ST_IDLE, !busy)
  `LPR_ASSERT_IMPL(a_fin_clear_sweep, clk, rst, cmd.fin_wr, state == lpr_pkg::ST_FIN_DIV)
  `LPR_ASSERT_NEXT(a_acc_follows, clk, rst, state == lpr_pkg::ST_ACC_RD,
    state == lpr_pkg::ST_ACC_WR)
endmodule
`default_nettype wire

// ----- sv/lloyd_palette_refiner_unit.sv -----
`default_nettype none
// Palette refiner: one Lloyd pass over up to 256 five-bit RGB palette entries.
// Commands enter on start while busy is low; each gives one result word marked
// by done, which is high for exactly one cycle. The receiver cannot stall, so
// results are never held back.
// Load and read go through a report read state and a report state. A bin
// scans the entries in use through the palette memory read port, one entry per
// cycle, then updates the accumulators of the best entry. Finish walks all 256
// entries: one without weight goes straight to its clearing write; one with
// weight first runs a bit-serial division (three channels in parallel) and
// writes the rounded means back to the palette memory.
// After reset a clearing pass over all 256 entries zeroes the accumulators;
// busy is high during it. palette_size resets to 16. The user must write it
// over the APB port at address 0 while the block is idle; it is not enforced.
module lloyd_palette_refiner_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [1:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [1:0]   operation,
  input  wire logic [7:0]   entry_index,
  input  wire logic [4:0]   red,
  input  wire logic [4:0]   green,
  input  wire logic [4:0]   blue,
  input  wire logic [23:0]  pixel_count,
  output logic              done,
  output logic [7:0]        result_index,
  output logic [13:0]       result_distance,
  output logic [4:0]        result_red,
  output logic [4:0]        result_green,
  output logic [4:0]        result_blue
);
  logic [lpr_pkg::SizeW-1:0] palette_size;
  lpr_pkg::cmd_t cmd;
  lpr_pkg::status_t status;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      palette_size <= lpr_pkg::SizeW'(16);
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      palette_size <= pwdata[lpr_pkg::SizeW-1:0];
    end
  end
  assign prdata = (paddr == 2'd0) ? {23'd0, palette_size} : 32'd0;

  lpr_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .operation(operation),
    .entry_index(entry_index), .palette_size(palette_size),
    .status(status), .cmd(cmd), .busy(busy)
  );

  lpr_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .operation(operation), .entry_index(entry_index), .red(red),
    .green(green), .blue(blue), .pixel_count(pixel_count), .done(done),
    .result_index(result_index), .result_distance(result_distance),
    .result_red(result_red), .result_green(result_green),
    .result_blue(result_blue)
  );
endmodule
`default_nettype wire
